>>> design/rala_pkg.sv
// Shared types and constants for the route and ARP lookup block.
// No dependencies; every other design file but rala_ram uses this package.
package rala_pkg;

  // Default table depths.
  localparam int unsigned ROUTE_ENTRIES_DEF = 1024;
  localparam int unsigned ARP_ENTRIES_DEF   = 8;

  // Field widths of the request and response.
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned IP_W     = 32;
  localparam int unsigned PORT_W   = 4;
  localparam int unsigned MAC_W    = 48;

  // Configuration register widths.
  localparam int unsigned RCOUNT_W   = 11;
  localparam int unsigned ACOUNT_W   = 4;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CFG_IDX_W  = 1;

  // Depth of the queue between the front and the back.
  localparam int unsigned QDEPTH = 2;

  // Action codes of an incoming request.
  typedef enum logic [ACTION_W-1:0] {
    ACT_ROUTE_WR = 2'd0,
    ACT_ARP_WR   = 2'd1,
    ACT_LOOKUP   = 2'd2
  } action_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROUTE_COUNT = 1'b0,
    REG_ARP_COUNT   = 1'b1
  } cfg_reg_e;

  // Operations passed from the front to the back.
  typedef enum logic [1:0] {
    OP_ROUTE_WR,
    OP_ARP_WR,
    OP_LOOKUP
  } op_e;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUTE,
    ST_ARP,
    ST_DONE
  } back_state_e;

  typedef struct packed {
    op_e                 op;
    logic [INDEX_W-1:0]  index;
    logic [IP_W-1:0]     address;
    logic [IP_W-1:0]     mask;
    logic [IP_W-1:0]     hop;
    logic [PORT_W-1:0]   port;
    logic [MAC_W-1:0]    mac;
  } q_entry_t;

  // Head of the queue as seen by the back.
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  typedef struct packed {
    logic [IP_W-1:0]   prefix;
    logic [IP_W-1:0]   mask;
    logic [IP_W-1:0]   hop;
    logic [PORT_W-1:0] port;
  } route_entry_t;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } arp_entry_t;

endpackage

>>> design/rala_if.sv
// Request and response channel interfaces with valid/ready handshake.
// Depends on rala_pkg for the field widths.
interface rala_req_if;
  logic                            valid;
  logic                            ready;
  logic [rala_pkg::ACTION_W-1:0]   action;
  logic [rala_pkg::INDEX_W-1:0]    index;
  logic [rala_pkg::IP_W-1:0]       address;
  logic [rala_pkg::IP_W-1:0]       mask;
  logic [rala_pkg::IP_W-1:0]       hop_address;
  logic [rala_pkg::PORT_W-1:0]     port;
  logic [rala_pkg::MAC_W-1:0]      mac;

  modport source (output valid, action, index, address, mask, hop_address, port, mac,
                  input ready);
  modport sink   (input valid, action, index, address, mask, hop_address, port, mac,
                  output ready);
endinterface

interface rala_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            route_found;
  logic [rala_pkg::IP_W-1:0]       matched_mask;
  logic [rala_pkg::IP_W-1:0]       hop_ip;
  logic [rala_pkg::PORT_W-1:0]     out_port;
  logic                            mac_found;
  logic [rala_pkg::MAC_W-1:0]      hop_mac;

  modport source (output valid, route_found, matched_mask, hop_ip, out_port, mac_found,
                  hop_mac, input ready);
  modport sink   (input valid, route_found, matched_mask, hop_ip, out_port, mac_found,
                  hop_mac, output ready);
endinterface

>>> design/rala_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rala_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/rala_front.sv
// Front end: accepts requests, classifies them and queues the useful ones.
// Depends on rala_pkg and the rala_req_if interface.
module rala_front #(
  parameter int unsigned ROUTE_ENTRIES = rala_pkg::ROUTE_ENTRIES_DEF,
  parameter int unsigned ARP_ENTRIES   = rala_pkg::ARP_ENTRIES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rala_req_if.sink          req_i,
  input  logic              pop_i,
  output rala_pkg::q_head_t head_o
);
  import rala_pkg::*;

  localparam int unsigned QP_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QC_W = $clog2(QDEPTH + 1);

  q_entry_t          fifo_q [QDEPTH];
  logic [QP_W-1:0]   wptr_q, wptr_d;
  logic [QP_W-1:0]   rptr_q, rptr_d;
  logic [QC_W-1:0]   cnt_q, cnt_d;
  logic              accept;
  logic              keep;
  logic              push;
  logic              pop;
  q_entry_t          entry;

  // Classify the request: writes beyond a table and unknown actions are dropped.
  always_comb begin
    keep     = 1'b0;
    entry.op = OP_LOOKUP;
    unique case (action_e'(req_i.action))
      ACT_ROUTE_WR: begin
        keep     = 32'(req_i.index) < ROUTE_ENTRIES;
        entry.op = OP_ROUTE_WR;
      end
      ACT_ARP_WR: begin
        keep     = 32'(req_i.index) < ARP_ENTRIES;
        entry.op = OP_ARP_WR;
      end
      ACT_LOOKUP: begin
        keep     = 1'b1;
        entry.op = OP_LOOKUP;
      end
      default: keep = 1'b0;
    endcase
    entry.index   = req_i.index;
    entry.address = req_i.address;
    entry.mask    = req_i.mask;
    entry.hop     = req_i.hop_address;
    entry.port    = req_i.port;
    entry.mac     = req_i.mac;
  end

  assign req_i.ready = (cnt_q != QC_W'(QDEPTH));
  assign accept      = req_i.valid && req_i.ready;
  assign push        = accept && keep;
  assign pop         = pop_i && (cnt_q != '0);

  // Queue pointer and fill count update.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = QP_W'(wptr_q + 1'b1);
    end
    if (pop) begin
      rptr_d = QP_W'(rptr_q + 1'b1);
    end
    if (push && !pop) begin
      cnt_d = QC_W'(cnt_q + 1'b1);
    end else if (pop && !push) begin
      cnt_d = QC_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= entry;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.entry = fifo_q[rptr_q];

endmodule

>>> design/rala_back.sv
// Back end: applies table writes and runs the route and ARP table scans.
// Depends on rala_pkg, rala_ram and the rala_rsp_if interface.
module rala_back #(
  parameter int unsigned ROUTE_ENTRIES = rala_pkg::ROUTE_ENTRIES_DEF,
  parameter int unsigned ARP_ENTRIES   = rala_pkg::ARP_ENTRIES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [rala_pkg::RCOUNT_W-1:0]   route_count_i,
  input  logic [rala_pkg::ACOUNT_W-1:0]   arp_count_i,
  input  rala_pkg::q_head_t               head_i,
  output logic                            pop_o,
  rala_rsp_if.source                      rsp_o
);
  import rala_pkg::*;

  localparam int unsigned RA_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int unsigned AA_W = (ARP_ENTRIES > 1) ? $clog2(ARP_ENTRIES) : 1;
  localparam int unsigned RC_W = $clog2(ROUTE_ENTRIES + 1);
  localparam int unsigned AC_W = $clog2(ARP_ENTRIES + 1);
  localparam int unsigned RT_W = $bits(route_entry_t);
  localparam int unsigned AR_W = $bits(arp_entry_t);

  back_state_e        state_q, state_d;
  logic [RC_W-1:0]    rissue_q, rissue_d;
  logic [AC_W-1:0]    aissue_q, aissue_d;
  logic               pend_q, pend_d;
  logic               rfound_q, rfound_d;
  logic               mfound_q, mfound_d;
  logic               ovalid_q, ovalid_d;
  logic [IP_W-1:0]    dest_q, dest_d;
  logic [IP_W-1:0]    bmask_q, bmask_d;
  logic [IP_W-1:0]    bhop_q, bhop_d;
  logic [PORT_W-1:0]  bport_q, bport_d;
  logic [MAC_W-1:0]   bmac_q, bmac_d;
  logic               orfound_q, orfound_d;
  logic [IP_W-1:0]    omask_q, omask_d;
  logic [IP_W-1:0]    ohop_q, ohop_d;
  logic [PORT_W-1:0]  oport_q, oport_d;
  logic               omfound_q, omfound_d;
  logic [MAC_W-1:0]   omac_q, omac_d;

  logic [RC_W-1:0]    rlimit;
  logic [AC_W-1:0]    alimit;
  logic               route_we;
  logic               arp_we;
  logic [RT_W-1:0]    route_wdata;
  logic [AR_W-1:0]    arp_wdata;
  logic [RT_W-1:0]    route_rdata;
  logic [AR_W-1:0]    arp_rdata;
  route_entry_t       route_wr;
  arp_entry_t         arp_wr;
  route_entry_t       route_rd;
  arp_entry_t         arp_rd;
  logic               route_hit;
  logic               route_better;

  // Entries in use, capped at the table depths.
  assign rlimit = (32'(route_count_i) > ROUTE_ENTRIES) ? RC_W'(ROUTE_ENTRIES)
                                                       : RC_W'(route_count_i);
  assign alimit = (32'(arp_count_i) > ARP_ENTRIES) ? AC_W'(ARP_ENTRIES)
                                                   : AC_W'(arp_count_i);

  // Write data straight from the queue head.
  always_comb begin
    route_wr.prefix = head_i.entry.address;
    route_wr.mask   = head_i.entry.mask;
    route_wr.hop    = head_i.entry.hop;
    route_wr.port   = head_i.entry.port;
    arp_wr.ip       = head_i.entry.address;
    arp_wr.mac      = head_i.entry.mac;
  end
  assign route_wdata = route_wr;
  assign arp_wdata   = arp_wr;

  rala_ram #(
    .WIDTH (RT_W),
    .DEPTH (ROUTE_ENTRIES)
  ) u_route_ram (
    .clk_i   (clk_i),
    .we_i    (route_we),
    .waddr_i (RA_W'(head_i.entry.index)),
    .wdata_i (route_wdata),
    .raddr_i (rissue_q[RA_W-1:0]),
    .rdata_o (route_rdata)
  );

  rala_ram #(
    .WIDTH (AR_W),
    .DEPTH (ARP_ENTRIES)
  ) u_arp_ram (
    .clk_i   (clk_i),
    .we_i    (arp_we),
    .waddr_i (AA_W'(head_i.entry.index)),
    .wdata_i (arp_wdata),
    .raddr_i (aissue_q[AA_W-1:0]),
    .rdata_o (arp_rdata)
  );

  // Compare stage on the entry read in the previous cycle.
  assign route_rd     = route_rdata;
  assign arp_rd       = arp_rdata;
  assign route_hit    = (dest_q & route_rd.mask) == route_rd.prefix;
  assign route_better = !rfound_q || (route_rd.mask > bmask_q);

  // Sequencer: next state, table writes and scan bookkeeping.
  always_comb begin
    state_d   = state_q;
    rissue_d  = rissue_q;
    aissue_d  = aissue_q;
    pend_d    = pend_q;
    rfound_d  = rfound_q;
    mfound_d  = mfound_q;
    dest_d    = dest_q;
    bmask_d   = bmask_q;
    bhop_d    = bhop_q;
    bport_d   = bport_q;
    bmac_d    = bmac_q;
    ovalid_d  = ovalid_q;
    orfound_d = orfound_q;
    omask_d   = omask_q;
    ohop_d    = ohop_q;
    oport_d   = oport_q;
    omfound_d = omfound_q;
    omac_d    = omac_q;
    route_we  = 1'b0;
    arp_we    = 1'b0;
    pop_o     = 1'b0;

    // The response register empties when the sink takes it.
    if (ovalid_q && rsp_o.ready) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          unique case (head_i.entry.op)
            OP_ROUTE_WR: route_we = 1'b1;
            OP_ARP_WR:   arp_we   = 1'b1;
            OP_LOOKUP: begin
              dest_d   = head_i.entry.address;
              rissue_d = '0;
              pend_d   = 1'b0;
              rfound_d = 1'b0;
              mfound_d = 1'b0;
              bmask_d  = '0;
              bhop_d   = '0;
              bport_d  = '0;
              bmac_d   = '0;
              state_d  = ST_ROUTE;
            end
            default: pop_o = 1'b1;
          endcase
        end
      end

      ST_ROUTE: begin
        if (pend_q && route_hit && route_better) begin
          rfound_d = 1'b1;
          bmask_d  = route_rd.mask;
          bhop_d   = route_rd.hop;
          bport_d  = route_rd.port;
        end
        if (rissue_q < rlimit) begin
          pend_d   = 1'b1;
          rissue_d = RC_W'(rissue_q + 1'b1);
        end else begin
          pend_d   = 1'b0;
          aissue_d = '0;
          if (!pend_q) begin
            state_d = rfound_q ? ST_ARP : ST_DONE;
          end
        end
      end

      ST_ARP: begin
        // A later matching entry overrides an earlier one.
        if (pend_q && (arp_rd.ip == bhop_q)) begin
          mfound_d = 1'b1;
          bmac_d   = arp_rd.mac;
        end
        if (aissue_q < alimit) begin
          pend_d   = 1'b1;
          aissue_d = AC_W'(aissue_q + 1'b1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (!ovalid_q || rsp_o.ready) begin
          ovalid_d  = 1'b1;
          orfound_d = rfound_q;
          omask_d   = bmask_q;
          ohop_d    = bhop_q;
          oport_d   = bport_q;
          omfound_d = mfound_q;
          omac_d    = bmac_q;
          state_d   = ST_IDLE;
        end
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rissue_q <= '0;
      aissue_q <= '0;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rissue_q <= rissue_d;
      aissue_q <= aissue_d;
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Search and response payload registers.
  always_ff @(posedge clk_i) begin
    rfound_q  <= rfound_d;
    mfound_q  <= mfound_d;
    dest_q    <= dest_d;
    bmask_q   <= bmask_d;
    bhop_q    <= bhop_d;
    bport_q   <= bport_d;
    bmac_q    <= bmac_d;
    orfound_q <= orfound_d;
    omask_q   <= omask_d;
    ohop_q    <= ohop_d;
    oport_q   <= oport_d;
    omfound_q <= omfound_d;
    omac_q    <= omac_d;
  end

  assign rsp_o.valid        = ovalid_q;
  assign rsp_o.route_found  = orfound_q;
  assign rsp_o.matched_mask = omask_q;
  assign rsp_o.hop_ip       = ohop_q;
  assign rsp_o.out_port     = oport_q;
  assign rsp_o.mac_found    = omfound_q;
  assign rsp_o.hop_mac      = omac_q;

endmodule

>>> design/route_and_arp_lookup.sv
// IPv4 longest-prefix-match route lookup with static ARP resolution. A request
// either writes one route entry, writes one ARP entry, or looks up a destination;
// only a lookup produces a response. A lookup reads every route entry in use from
// the route RAM, one entry per cycle through its single read port, keeps the
// matching entry with the largest mask (lowest index on a tie), and, if a route
// matched, scans the ARP entries in use the same way (highest index wins). A
// lookup occupies the back end in turn with the idle state that starts it, the
// route scan, the ARP scan when a route matched, and the done state that loads
// the response, waiting there while the response register is full; each scan
// covers its entry count, capped at the table depth. A table write is applied
// in the idle state. Requests are accepted into a two-entry queue while the back
// end is busy, and a finished response waits in its own register. Tables are
// undefined until written; the counts are written only while the block is idle,
// which the user must ensure; the block itself does not enforce it.
// Depends on rala_pkg, rala_if, rala_ram, rala_front and rala_back.
module route_and_arp_lookup #(
  parameter int unsigned ROUTE_ENTRIES = rala_pkg::ROUTE_ENTRIES_DEF,
  parameter int unsigned ARP_ENTRIES   = rala_pkg::ARP_ENTRIES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rala_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rala_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  rala_req_if.sink                          req_i,
  rala_rsp_if.source                        rsp_o
);
  import rala_pkg::*;

  logic [RCOUNT_W-1:0] route_count_q;
  logic [ACOUNT_W-1:0] arp_count_q;
  q_head_t             head;
  logic                pop;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      route_count_q <= '0;
      arp_count_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ROUTE_COUNT: route_count_q <= cfg_data_i[RCOUNT_W-1:0];
        REG_ARP_COUNT:   arp_count_q   <= cfg_data_i[ACOUNT_W-1:0];
      endcase
    end
  end

  rala_front #(
    .ROUTE_ENTRIES (ROUTE_ENTRIES),
    .ARP_ENTRIES   (ARP_ENTRIES)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .pop_i  (pop),
    .head_o (head)
  );

  rala_back #(
    .ROUTE_ENTRIES (ROUTE_ENTRIES),
    .ARP_ENTRIES   (ARP_ENTRIES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .route_count_i (route_count_q),
    .arp_count_i   (arp_count_q),
    .head_i        (head),
    .pop_o         (pop),
    .rsp_o         (rsp_o)
  );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for route_and_arp_lookup: fills the route and ARP tables through
// requests, predicts every lookup response with its own table copy, and checks each response.
// Depends on rala_pkg, the rala_if channel interfaces and the design files of the block.
module tb_top;
  import rala_pkg::*;

  localparam int unsigned ROUTE_DEPTH  = ROUTE_ENTRIES_DEF;
  localparam int unsigned ARP_DEPTH    = ARP_ENTRIES_DEF;
  localparam int unsigned ARP_AW       = (ARP_DEPTH > 1) ? $clog2(ARP_DEPTH) : 1;
  localparam int unsigned INDEX_MAX    = (1 << INDEX_W) - 1;
  localparam int unsigned CFG_MAX      = (1 << CFG_DATA_W) - 1;
  localparam int unsigned ACOUNT_MAX   = (1 << ACOUNT_W) - 1;
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned BASE_POOL    = 4;
  localparam int unsigned HOP_POOL     = 8;

  // The action code that the block must ignore.
  localparam logic [ACTION_W-1:0] ACT_UNUSED  = 2'd3;
  localparam logic [IP_W-1:0]     ALL_ONES_IP = '1;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  index;
    logic [IP_W-1:0]     address;
    logic [IP_W-1:0]     mask;
    logic [IP_W-1:0]     hop;
    logic [PORT_W-1:0]   port;
    logic [MAC_W-1:0]    mac;
  } lookup_req_t;

  typedef struct packed {
    logic              route_found;
    logic [IP_W-1:0]   matched_mask;
    logic [IP_W-1:0]   hop_ip;
    logic [PORT_W-1:0] out_port;
    logic              mac_found;
    logic [MAC_W-1:0]  hop_mac;
  } lookup_rsp_t;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rala_req_if req_if ();
  rala_rsp_if rsp_if ();

  route_and_arp_lookup i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // Shadow copy of the tables and the count registers.
  logic [IP_W-1:0]   rt_prefix [ROUTE_DEPTH];
  logic [IP_W-1:0]   rt_mask   [ROUTE_DEPTH];
  logic [IP_W-1:0]   rt_hop    [ROUTE_DEPTH];
  logic [PORT_W-1:0] rt_port   [ROUTE_DEPTH];
  logic [IP_W-1:0]   arp_ip    [ARP_DEPTH];
  logic [MAC_W-1:0]  arp_mac   [ARP_DEPTH];
  bit                rt_written  [ROUTE_DEPTH];
  bit                arp_written [ARP_DEPTH];
  int unsigned       route_count_q;
  int unsigned       arp_count_q;

  lookup_rsp_t       pending_lookups [$];
  int unsigned       error_count  = 0;
  int unsigned       stall_cycles = 0;
  int unsigned       random_sent  = 0;
  int unsigned       src_idle_pct;
  int unsigned       sink_idle_pct;
  logic [IP_W-1:0]   base_pool [BASE_POOL];
  logic [IP_W-1:0]   hop_pool  [HOP_POOL];

  always #10 clk_i = ~clk_i;

  // Saturated counts, as the block scans them.
  function automatic int unsigned used_routes();
    return (route_count_q > ROUTE_DEPTH) ? ROUTE_DEPTH : route_count_q;
  endfunction

  function automatic int unsigned used_arps();
    return (arp_count_q > ARP_DEPTH) ? ARP_DEPTH : arp_count_q;
  endfunction

  // Longest-prefix match over the routes in use, then the ARP scan on the winning hop.
  function automatic lookup_rsp_t predict_lookup(logic [IP_W-1:0] dest);
    lookup_rsp_t r = '0;
    for (int unsigned i = 0; i < used_routes(); i++) begin
      if ((dest & rt_mask[i]) == rt_prefix[i] && (!r.route_found || rt_mask[i] > r.matched_mask)) begin
        r.route_found  = 1'b1;
        r.matched_mask = rt_mask[i];
        r.hop_ip       = rt_hop[i];
        r.out_port     = rt_port[i];
      end
    end
    if (r.route_found) begin
      for (int unsigned i = 0; i < used_arps(); i++) begin
        if (arp_ip[i] == r.hop_ip) begin
          r.mac_found = 1'b1;
          r.hop_mac   = arp_mac[i];
        end
      end
    end
    return r;
  endfunction

  // Update the shadow tables for an accepted request, or queue the expected response.
  function automatic void apply_request(lookup_req_t it);
    case (it.action)
      ACT_ROUTE_WR: begin
        if (it.index < ROUTE_DEPTH) begin
          rt_prefix[it.index]  = it.address;
          rt_mask[it.index]    = it.mask;
          rt_hop[it.index]     = it.hop;
          rt_port[it.index]    = it.port;
          rt_written[it.index] = 1'b1;
        end
      end
      ACT_ARP_WR: begin
        if (it.index < ARP_DEPTH) begin
          arp_ip[it.index[ARP_AW-1:0]]      = it.address;
          arp_mac[it.index[ARP_AW-1:0]]     = it.mac;
          arp_written[it.index[ARP_AW-1:0]] = 1'b1;
        end
      end
      ACT_LOOKUP: pending_lookups.push_back(predict_lookup(it.address));
      default: ;
    endcase
  endfunction

  function automatic void report_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got)
      report_error($sformatf("%s: expected 0x%0h, got 0x%0h", name, want, got));
  endfunction

  // Compare one accepted response with the oldest pending lookup.
  function automatic void check_response();
    lookup_rsp_t want;
    if (pending_lookups.size() == 0) begin
      report_error("response arrived with no lookup pending");
      return;
    end
    want = pending_lookups.pop_front();
    compare_field("route_found", want.route_found, rsp_if.route_found);
    compare_field("matched_mask", want.matched_mask, rsp_if.matched_mask);
    compare_field("hop_ip", want.hop_ip, rsp_if.hop_ip);
    compare_field("out_port", want.out_port, rsp_if.out_port);
    compare_field("mac_found", want.mac_found, rsp_if.mac_found);
    compare_field("hop_mac", want.hop_mac, rsp_if.hop_mac);
  endfunction

  // Response side: check on each handshake, then pick the next ready value.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) check_response();
      rsp_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Watchdog: too many cycles without any handshake means the block is stuck.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Request builders.
  function automatic lookup_req_t scrambled_item();
    lookup_req_t it;
    it = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return it;
  endfunction

  function automatic logic [MAC_W-1:0] random_mac();
    logic [63:0] w = {$urandom, $urandom};
    return w[MAC_W-1:0];
  endfunction

  function automatic lookup_req_t route_write(int unsigned idx, logic [IP_W-1:0] prefix,
                                              logic [IP_W-1:0] mask, logic [IP_W-1:0] hop,
                                              logic [PORT_W-1:0] port);
    lookup_req_t it = scrambled_item();
    it.action  = ACT_ROUTE_WR;
    it.index   = INDEX_W'(idx);
    it.address = prefix;
    it.mask    = mask;
    it.hop     = hop;
    it.port    = port;
    return it;
  endfunction

  function automatic lookup_req_t arp_write(int unsigned idx, logic [IP_W-1:0] ip,
                                            logic [MAC_W-1:0] mac);
    lookup_req_t it = scrambled_item();
    it.action  = ACT_ARP_WR;
    it.index   = INDEX_W'(idx);
    it.address = ip;
    it.mac     = mac;
    return it;
  endfunction

  function automatic lookup_req_t lookup_for(logic [IP_W-1:0] dest);
    lookup_req_t it = scrambled_item();
    it.action  = ACT_LOOKUP;
    it.address = dest;
    return it;
  endfunction

  function automatic logic [IP_W-1:0] prefix_mask(int unsigned len);
    return (len == 0) ? '0 : (ALL_ONES_IP << (IP_W - len));
  endfunction

  // Prefix lengths cluster on the usual boundaries so that routes nest and tie.
  function automatic int unsigned random_prefix_len();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, IP_W);
      1, 2:    return 8;
      3, 4:    return 16;
      5, 6:    return 24;
      7:       return 32;
      default: return $urandom_range(1, IP_W);
    endcase
  endfunction

  function automatic lookup_req_t well_formed_route(int unsigned idx);
    logic [IP_W-1:0] mask = prefix_mask(random_prefix_len());
    logic [IP_W-1:0] base = base_pool[$urandom_range(0, BASE_POOL - 1)];
    return route_write(idx, base & mask, mask, hop_pool[$urandom_range(0, HOP_POOL - 1)],
                       PORT_W'($urandom));
  endfunction

  function automatic lookup_req_t random_arp(int unsigned idx);
    logic [IP_W-1:0] ip;
    ip = ($urandom_range(0, 9) < 8) ? hop_pool[$urandom_range(0, HOP_POOL - 1)] : $urandom;
    return arp_write(idx, ip, random_mac());
  endfunction

  // Destinations mostly fall inside a route in use, with random host bits.
  function automatic lookup_req_t random_lookup();
    int unsigned rn = used_routes();
    int unsigned pick = $urandom_range(0, 9);
    int unsigned i;
    logic [IP_W-1:0] host = $urandom;
    if (rn > 0 && pick < 8) begin
      i = $urandom_range(0, rn - 1);
      return lookup_for(rt_prefix[i] | (host & ~rt_mask[i]));
    end
    if (pick == 8)
      return lookup_for(base_pool[$urandom_range(0, BASE_POOL - 1)] ^ IP_W'(host[7:0]));
    return lookup_for(host);
  endfunction

  function automatic lookup_req_t random_item();
    int unsigned pick = $urandom_range(0, 99);
    int unsigned rn = used_routes();
    int unsigned idx;
    lookup_req_t it;
    if (pick < 45) return random_lookup();
    if (pick < 80) begin
      idx = (rn > 0 && $urandom_range(0, 9) < 7) ? $urandom_range(0, rn - 1)
                                                  : $urandom_range(0, INDEX_MAX);
      if ($urandom_range(0, 99) < 85) return well_formed_route(idx);
      it = scrambled_item();
      it.action = ACT_ROUTE_WR;
      it.index  = INDEX_W'(idx);
      return it;
    end
    if (pick < 94) begin
      idx = ($urandom_range(0, 9) == 0) ? $urandom_range(ARP_DEPTH, INDEX_MAX)
                                         : $urandom_range(0, ARP_DEPTH - 1);
      return random_arp(idx);
    end
    it = scrambled_item();
    it.action = (pick < 97) ? ACT_UNUSED : ACT_LOOKUP;
    return it;
  endfunction

  // Offer one request, idling first at random, and hold it until it is accepted.
  task automatic send_request(input lookup_req_t it);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.action      <= it.action;
    req_if.index       <= it.index;
    req_if.address     <= it.address;
    req_if.mask        <= it.mask;
    req_if.hop_address <= it.hop;
    req_if.port        <= it.port;
    req_if.mac         <= it.mac;
    do @(posedge clk_i); while (!req_if.ready);
    apply_request(it);
  endtask

  // Stop offering requests and wait for every pending lookup to come back.
  task automatic wait_results();
    req_if.valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
  endtask

  // Also let trailing table writes drain out of the block.
  task automatic wait_idle();
    wait_results();
    repeat (used_routes() + used_arps() + 16) @(posedge clk_i);
  endtask

  task automatic write_count(input cfg_reg_e which, input int unsigned value);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= which;
    cfg_data_i <= CFG_DATA_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (which == REG_ROUTE_COUNT) begin
      route_count_q = value & ((1 << RCOUNT_W) - 1);
    end else begin
      arp_count_q = value & ((1 << ACOUNT_W) - 1);
    end
  endtask

  // Entries must hold data before a count brings them into use.
  task automatic set_counts(input int unsigned rn, input int unsigned an);
    for (int unsigned i = 0; i < rn && i < ROUTE_DEPTH; i++)
      if (!rt_written[i]) send_request(well_formed_route(i));
    for (int unsigned i = 0; i < an && i < ARP_DEPTH; i++)
      if (!arp_written[i]) send_request(random_arp(i));
    write_count(REG_ROUTE_COUNT, rn);
    write_count(REG_ARP_COUNT, an);
  endtask

  // With both counts at zero a lookup finds nothing; an unused action is dropped.
  task automatic test_reset_state();
    lookup_req_t it = scrambled_item();
    send_request(lookup_for($urandom));
    it.action = ACT_UNUSED;
    send_request(it);
  endtask

  task automatic test_directed();
    logic [IP_W-1:0] hop_a = 32'hC0A8_0001;
    logic [IP_W-1:0] hop_b = 32'hC0A8_0002;
    logic [IP_W-1:0] hop_c = 32'hC0A8_0003;
    logic [IP_W-1:0] hop_d = 32'h0A0A_0A0A;
    // Nested prefixes, two routes with equal masks, host routes at both ends of the
    // address space, a default route, and the last table index.
    send_request(route_write(0, 32'h0A00_0000, 32'hFF00_0000, hop_a, 4'd0));
    send_request(route_write(1, 32'h0A01_0000, 32'hFFFF_0000, hop_b, 4'd15));
    send_request(route_write(2, 32'h0A01_0000, 32'hFFFF_0000, hop_c, 4'd5));
    send_request(route_write(3, ALL_ONES_IP, ALL_ONES_IP, ALL_ONES_IP, 4'd15));
    send_request(route_write(4, '0, ALL_ONES_IP, '0, 4'd0));
    send_request(route_write(5, '0, '0, hop_d, 4'd9));
    send_request(route_write(INDEX_MAX, 32'hC0A8_0000, 32'hFFFF_0000, hop_a, 4'd3));
    // A repeated ARP IP where the later entry must win, MAC extremes, and writes past
    // the end of the ARP table that must be dropped.
    send_request(arp_write(0, hop_a, '0));
    send_request(arp_write(1, hop_b, '1));
    send_request(arp_write(2, hop_b, 48'h0123_4567_89AB));
    send_request(arp_write(3, '0, 48'h5A5A_A5A5_F00D));
    for (int unsigned i = 4; i < ARP_DEPTH - 1; i++) send_request(arp_write(i, $urandom, random_mac()));
    send_request(arp_write(ARP_DEPTH - 1, hop_d, 48'hFEDC_BA98_7654));
    send_request(arp_write(ARP_DEPTH, hop_d, '0));
    send_request(arp_write(INDEX_MAX, hop_b, '0));

    // The default route is left out of use first, so a miss is possible.
    write_count(REG_ROUTE_COUNT, 5);
    write_count(REG_ARP_COUNT, ARP_DEPTH);
    send_request(lookup_for(32'h0A01_0203));
    send_request(lookup_for(32'h0AC8_0001));
    send_request(lookup_for(ALL_ONES_IP));
    send_request(lookup_for('0));
    send_request(lookup_for(32'h0B00_0001));

    // Default route in use, ARP table out of use.
    write_count(REG_ROUTE_COUNT, 6);
    write_count(REG_ARP_COUNT, 0);
    send_request(lookup_for(32'h0B00_0001));

    // An ARP count past the table depth scans the whole table.
    write_count(REG_ARP_COUNT, ACOUNT_MAX);
    send_request(lookup_for(32'h0B00_0001));
  endtask

  // Phases with fresh counts and random requests, until the running total reaches goal.
  task automatic test_random(input int unsigned goal);
    int unsigned rn;
    int unsigned an;
    int unsigned n;
    lookup_req_t it;
    while (random_sent < goal) begin
      case ($urandom_range(0, 9))
        0:       rn = 0;
        1:       rn = 1;
        2:       rn = $urandom_range(64, 128);
        default: rn = $urandom_range(2, 32);
      endcase
      an = ($urandom_range(0, 5) == 0) ? $urandom_range(ARP_DEPTH + 1, ACOUNT_MAX)
                                       : $urandom_range(0, ARP_DEPTH);
      foreach (base_pool[i]) base_pool[i] = $urandom;
      set_counts(rn, an);
      n = $urandom_range(25, 50);
      for (int unsigned k = 0; k < n; k++) begin
        // Halfway through, hold off until every lookup has been answered.
        if (k == n / 2) wait_results();
        it = random_item();
        send_request(it);
        if (it.action != ACT_UNUSED && !(it.action == ACT_ARP_WR && it.index >= ARP_DEPTH))
          random_sent++;
      end
    end
  endtask

  // Whole route table in use, then a route count beyond the table depth, then one short of it.
  task automatic test_full_table();
    logic [IP_W-1:0] host = $urandom;
    for (int unsigned i = 0; i < ROUTE_DEPTH - 1; i++) send_request(well_formed_route(i));
    send_request(route_write(ROUTE_DEPTH - 1, host, ALL_ONES_IP, hop_pool[0], PORT_W'($urandom)));
    set_counts(ROUTE_DEPTH, ARP_DEPTH);
    send_request(lookup_for(host));
    repeat (3) send_request(random_lookup());
    write_count(REG_ROUTE_COUNT, CFG_MAX);
    send_request(lookup_for(host));
    repeat (2) send_request(random_lookup());
    write_count(REG_ROUTE_COUNT, ROUTE_DEPTH - 1);
    send_request(lookup_for(host));
  endtask

  initial begin
    req_if.valid       = 1'b0;
    req_if.action      = ACT_LOOKUP;
    req_if.index       = '0;
    req_if.address     = '0;
    req_if.mask        = '0;
    req_if.hop_address = '0;
    req_if.port        = '0;
    req_if.mac         = '0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = REG_ROUTE_COUNT;
    cfg_data_i         = '0;
    route_count_q      = 0;
    arp_count_q        = 0;
    foreach (rt_prefix[i]) begin
      rt_prefix[i]  = '0;
      rt_mask[i]    = '0;
      rt_hop[i]     = '0;
      rt_port[i]    = '0;
      rt_written[i] = 1'b0;
    end
    foreach (arp_ip[i]) begin
      arp_ip[i]      = '0;
      arp_mac[i]     = '0;
      arp_written[i] = 1'b0;
    end
    foreach (base_pool[i]) base_pool[i] = $urandom;
    foreach (hop_pool[i]) hop_pool[i] = $urandom;
    src_idle_pct  = 38;
    sink_idle_pct = 79;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_directed();
    test_random(RANDOM_ITEMS / 3);
    src_idle_pct  = 79;
    sink_idle_pct = 38;
    test_random(2 * RANDOM_ITEMS / 3);
    test_full_table();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random(RANDOM_ITEMS);

    wait_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
